/* rtl/lcdn_pkg.sv */
// Shared types and constants for the character LCD nibble interface.
`default_nettype none
package lcdn_pkg;

   localparam logic [3:0] REQ_CHAR    = 4'd0;
   localparam logic [3:0] REQ_COMMAND = 4'd1;
   localparam logic [3:0] REQ_POS     = 4'd2;
   localparam logic [3:0] REQ_CONTROL = 4'd3;
   localparam logic [3:0] REQ_CLEAR   = 4'd4;
   localparam logic [3:0] REQ_HOME    = 4'd5;
   localparam logic [3:0] REQ_GLYPH   = 4'd6;
   localparam logic [3:0] REQ_ROW     = 4'd7;
   localparam logic [3:0] REQ_INIT    = 4'd8;

   localparam logic [1:0] SEL_DISPLAY = 2'd0;
   localparam logic [1:0] SEL_CURSOR  = 2'd1;
   localparam logic [1:0] SEL_BLINK   = 2'd2;

   localparam logic [0:0] CSR_COLUMNS = 1'd0;
   localparam logic [0:0] CSR_LINES   = 1'd1;

   localparam logic [7:0] CMD_CLEAR = 8'h01;
   localparam logic [7:0] CMD_HOME  = 8'h02;
   localparam logic [7:0] CMD_ENTRY = 8'h04;
   localparam logic [7:0] CMD_CTRL  = 8'h08;
   localparam logic [7:0] CMD_SHIFT = 8'h10;
   localparam logic [7:0] CMD_FUNC  = 8'h20;
   localparam logic [7:0] CMD_CGRAM = 8'h40;
   localparam logic [7:0] CMD_DDRAM = 8'h80;

   localparam logic [5:0] MS_NONE = 6'd0;
   localparam logic [5:0] MS_CMD  = 6'd2;
   localparam logic [5:0] MS_HOME = 6'd7;
   localparam logic [5:0] MS_WAKE = 6'd35;
   localparam logic [5:0] MS_FUNC = 6'd37;

   localparam logic [3:0] INIT_WORDS = 4'd12;

   typedef struct packed {
      logic       rs;
      logic [7:0] data;
      logic [5:0] ms;
      logic       single;
      logic       last;
   } lcdn_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } lcdn_qstat_type;

   function automatic logic [7:0] line_offset(input logic [1:0] ln);
      logic [7:0] off;
      case (ln)
         2'd0: off = 8'h00;
         2'd1: off = 8'h40;
         2'd2: off = 8'h14;
         default: off = 8'h54;
      endcase
      return off;
   endfunction

endpackage
`default_nettype wire

/* rtl/char_lcd_nibble_interface_core.sv */
// Top level of the character LCD nibble interface: front end, byte queue and bus back end.
// The first nibble word of a request passes through the front-end registers, the queue and the output register.
// Throughput: one nibble word per cycle while the output is not stalled and the queue is not empty.
// A request holds the front end until it has pushed its byte words (init twelve); the queue lets
// it run ahead of a stalled output. A request that produces no writes leaves the front end idle.
// Synchronous reset clears cursor, control bits and byte mode, sets 16 columns and 2 lines,
// and empties the queue and output register.
`default_nettype none
module char_lcd_nibble_interface_core
   import lcdn_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [0:0] csr_index,
   input  wire logic [5:0] csr_wdata,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [3:0] req_type,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [5:0] req_column,
   input  wire logic [1:0] req_line,
   input  wire logic [1:0] req_control_select,
   input  wire logic       req_enable,
   input  wire logic [2:0] req_glyph_index,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_reg_select,
   output logic [3:0]      rsp_nibble,
   output logic [5:0]      rsp_settle_ms,
   output logic            rsp_last
);

   lcdn_qstat_type q_stat;
   lcdn_entry_type push_entry;
   lcdn_entry_type head_entry;
   logic           q_push;
   logic           q_pop;

   lcdn_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_data_byte      (req_data_byte),
      .req_column         (req_column),
      .req_line           (req_line),
      .req_control_select (req_control_select),
      .req_enable         (req_enable),
      .req_glyph_index    (req_glyph_index),
      .q_stat             (q_stat),
      .q_push             (q_push),
      .q_entry            (push_entry)
   );

   lcdn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .stat       (q_stat)
   );

   lcdn_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .q_stat         (q_stat),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reg_select (rsp_reg_select),
      .rsp_nibble     (rsp_nibble),
      .rsp_settle_ms  (rsp_settle_ms),
      .rsp_last       (rsp_last)
   );

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("byte word pushed into a full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("byte word popped from an empty queue");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && q_stat.empty && !req_stall))
      else $error("block not idle after reset");

endmodule
`default_nettype wire

/* rtl/lcdn_front.sv */
// Request front end: decodes requests, tracks cursor and control state, emits byte words.
`default_nettype none
module lcdn_front
   import lcdn_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_we,
   input  wire logic [0:0]     csr_index,
   input  wire logic [5:0]     csr_wdata,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic [3:0]     req_type,
   input  wire logic [7:0]     req_data_byte,
   input  wire logic [5:0]     req_column,
   input  wire logic [1:0]     req_line,
   input  wire logic [1:0]     req_control_select,
   input  wire logic           req_enable,
   input  wire logic [2:0]     req_glyph_index,
   input  wire lcdn_qstat_type q_stat,
   output logic                q_push,
   output lcdn_entry_type      q_entry
);

   logic [5:0] columns_ff, columns_in;
   logic [2:0] lines_ff, lines_in;
   logic [5:0] col_ff, col_in;
   logic [1:0] line_ff, line_in;
   logic [2:0] cb_ff, cb_in;
   logic       mode_ff, mode_in;

   logic       busy_ff, busy_in;
   logic [3:0] step_ff, step_in;
   logic [3:0] count_ff, count_in;
   logic       init_ff, init_in;
   logic       single_ff, single_in;
   logic       rs_a_ff, rs_a_in, rs_b_ff, rs_b_in;
   logic [7:0] byte_a_ff, byte_a_in, byte_b_ff, byte_b_in;
   logic [5:0] ms_a_ff, ms_a_in, ms_b_ff, ms_b_in;

   logic       accept;
   logic       finishing;
   logic [3:0] plan_count;
   logic       plan_rs_a, plan_rs_b;
   logic [7:0] plan_a, plan_b;
   logic [5:0] plan_ms_a, plan_ms_b;
   logic [5:0] next_col;
   logic [2:0] line_inc;
   logic [1:0] wrap_line;
   logic [2:0] mask;
   logic [2:0] new_cb;
   logic [2:0] init_cb;

   always_comb begin
      next_col  = col_ff + 6'd1;
      line_inc  = {1'b0, line_ff} + 3'd1;
      wrap_line = ((line_inc >= lines_ff) || line_inc[2]) ? 2'd0 : line_inc[1:0];
      case (req_control_select)
         SEL_DISPLAY: mask = 3'b100;
         SEL_CURSOR:  mask = 3'b010;
         SEL_BLINK:   mask = 3'b001;
         default:     mask = 3'b000;
      endcase
      new_cb = req_enable ? (cb_ff | mask) : (cb_ff & ~mask);
   end

   always_comb begin
      plan_count = 4'd0;
      plan_rs_a  = 1'b0;
      plan_rs_b  = 1'b0;
      plan_a     = req_data_byte;
      plan_b     = CMD_HOME;
      plan_ms_a  = MS_CMD;
      plan_ms_b  = MS_CMD;
      col_in     = col_ff;
      line_in    = line_ff;
      cb_in      = cb_ff;
      mode_in    = mode_ff;
      case (req_type)
         REQ_CHAR: begin
            plan_rs_a = 1'b1;
            plan_ms_a = MS_NONE;
            plan_b    = CMD_DDRAM | line_offset(wrap_line);
            if (next_col >= columns_ff) begin
               plan_count = 4'd2;
               col_in     = 6'd0;
               line_in    = wrap_line;
            end else begin
               plan_count = 4'd1;
               col_in     = next_col;
            end
         end
         REQ_COMMAND: begin
            plan_count = 4'd1;
         end
         REQ_POS: begin
            plan_a = (CMD_DDRAM | line_offset(req_line)) + {2'b00, req_column};
            if ((req_column < columns_ff) && ({1'b0, req_line} < lines_ff)) begin
               plan_count = 4'd1;
               col_in     = req_column;
               line_in    = req_line;
            end
         end
         REQ_CONTROL: begin
            plan_a = CMD_CTRL | {5'd0, new_cb};
            if (mask != 3'b000) begin
               plan_count = 4'd1;
               cb_in      = new_cb;
            end
         end
         REQ_CLEAR: begin
            plan_count = 4'd2;
            plan_a     = CMD_CLEAR;
            plan_ms_b  = MS_HOME;
            col_in     = 6'd0;
            line_in    = 2'd0;
         end
         REQ_HOME: begin
            plan_count = 4'd1;
            plan_a     = CMD_HOME;
            plan_ms_a  = MS_HOME;
            col_in     = 6'd0;
            line_in    = 2'd0;
         end
         REQ_GLYPH: begin
            plan_count = 4'd1;
            plan_a     = CMD_CGRAM | {2'b00, req_glyph_index, 3'b000};
         end
         REQ_ROW: begin
            plan_count = 4'd1;
            plan_rs_a  = 1'b1;
            plan_ms_a  = MS_NONE;
         end
         REQ_INIT: begin
            plan_count = INIT_WORDS;
            plan_a     = {5'd0, cb_ff};
            col_in     = 6'd0;
            line_in    = 2'd0;
            cb_in      = 3'b100;
            mode_in    = 1'b1;
         end
         default: begin
            plan_count = 4'd0;
         end
      endcase
   end

   always_comb begin
      init_cb            = byte_a_ff[2:0] | 3'b100;
      q_entry.rs         = 1'b0;
      q_entry.data       = byte_a_ff;
      q_entry.ms         = MS_CMD;
      q_entry.single     = single_ff;
      q_entry.last       = (step_ff == count_ff - 4'd1);
      if (init_ff) begin
         q_entry.single = 1'b0;
         case (step_ff)
            4'd0, 4'd1, 4'd2: begin
               q_entry.data   = 8'h03;
               q_entry.ms     = MS_WAKE;
               q_entry.single = 1'b1;
            end
            4'd3: begin
               q_entry.data   = 8'h02;
               q_entry.ms     = MS_WAKE;
               q_entry.single = 1'b1;
            end
            4'd4: begin
               q_entry.data = CMD_FUNC | 8'h08;
               q_entry.ms   = MS_FUNC;
            end
            4'd5:  q_entry.data = CMD_CTRL | {5'd0, init_cb};
            4'd6:  q_entry.data = CMD_CTRL | {5'd0, init_cb & 3'b101};
            4'd7:  q_entry.data = CMD_CTRL | 8'h04;
            4'd8:  q_entry.data = CMD_CLEAR;
            4'd9: begin
               q_entry.data = CMD_HOME;
               q_entry.ms   = MS_HOME;
            end
            4'd10: q_entry.data = CMD_ENTRY | 8'h02;
            default: q_entry.data = CMD_SHIFT | 8'h04;
         endcase
      end else if (step_ff != 4'd0) begin
         q_entry.rs   = rs_b_ff;
         q_entry.data = byte_b_ff;
         q_entry.ms   = ms_b_ff;
      end else begin
         q_entry.rs   = rs_a_ff;
         q_entry.ms   = ms_a_ff;
      end
   end

   assign q_push    = busy_ff & ~q_stat.full;
   assign finishing = q_push & q_entry.last;
   assign req_stall = busy_ff & ~finishing;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      columns_in = columns_ff;
      lines_in   = lines_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COLUMNS: columns_in = csr_wdata;
            CSR_LINES:   lines_in   = csr_wdata[2:0];
            default:     columns_in = columns_ff;
         endcase
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      init_in   = init_ff;
      single_in = single_ff;
      rs_a_in   = rs_a_ff;
      rs_b_in   = rs_b_ff;
      byte_a_in = byte_a_ff;
      byte_b_in = byte_b_ff;
      ms_a_in   = ms_a_ff;
      ms_b_in   = ms_b_ff;
      if (accept) begin
         busy_in   = (plan_count != 4'd0);
         step_in   = 4'd0;
         count_in  = plan_count;
         init_in   = (req_type == REQ_INIT);
         single_in = ~mode_ff;
         rs_a_in   = plan_rs_a;
         rs_b_in   = plan_rs_b;
         byte_a_in = plan_a;
         byte_b_in = plan_b;
         ms_a_in   = plan_ms_a;
         ms_b_in   = plan_ms_b;
      end else if (finishing) begin
         busy_in = 1'b0;
      end else if (q_push) begin
         step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= 6'd16;
         lines_ff   <= 3'd2;
         col_ff     <= 6'd0;
         line_ff    <= 2'd0;
         cb_ff      <= 3'd0;
         mode_ff    <= 1'b0;
         busy_ff    <= 1'b0;
         step_ff    <= 4'd0;
         count_ff   <= 4'd0;
         init_ff    <= 1'b0;
      end else begin
         columns_ff <= columns_in;
         lines_ff   <= lines_in;
         if (accept) begin
            col_ff  <= col_in;
            line_ff <= line_in;
            cb_ff   <= cb_in;
            mode_ff <= mode_in;
         end
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         init_ff  <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      single_ff <= single_in;
      rs_a_ff   <= rs_a_in;
      rs_b_ff   <= rs_b_in;
      byte_a_ff <= byte_a_in;
      byte_b_ff <= byte_b_in;
      ms_a_ff   <= ms_a_in;
      ms_b_ff   <= ms_b_in;
   end

endmodule
`default_nettype wire

/* rtl/lcdn_queue.sv */
// Small register queue of byte words between the front end and the bus back end.
`default_nettype none
module lcdn_queue
   import lcdn_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire lcdn_entry_type push_entry,
   input  wire logic           pop,
   output lcdn_entry_type      head_entry,
   output lcdn_qstat_type      stat
);

   // DEPTH must be a power of two so that the pointers wrap by themselves.
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   lcdn_entry_type mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [AW:0]    count_ff, count_in;

   assign stat.full  = (count_ff == (AW+1)'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (AW+1)'(1);
         2'b01:   count_in = count_ff - (AW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

/* rtl/lcdn_back.sv */
// Bus back end: splits queued byte words into nibble words in an output register.
`default_nettype none
module lcdn_back
   import lcdn_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire lcdn_entry_type head_entry,
   input  wire lcdn_qstat_type q_stat,
   output logic                q_pop,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic                rsp_reg_select,
   output logic [3:0]          rsp_nibble,
   output logic [5:0]          rsp_settle_ms,
   output logic                rsp_last
);

   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;
   logic       rs_ff, rs_in;
   logic [3:0] nib_ff, nib_in;
   logic [5:0] ms_ff, ms_in;
   logic       last_ff, last_in;
   logic       load;
   logic       low_half;

   assign load     = ~q_stat.empty & (~valid_ff | ~rsp_stall);
   assign low_half = head_entry.single | phase_ff;
   assign q_pop    = load & low_half;

   always_comb begin
      valid_in = valid_ff & rsp_stall;
      phase_in = phase_ff;
      rs_in    = rs_ff;
      nib_in   = nib_ff;
      ms_in    = ms_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         rs_in    = head_entry.rs;
         if (low_half) begin
            nib_in   = head_entry.data[3:0];
            ms_in    = head_entry.ms;
            last_in  = head_entry.last;
            phase_in = 1'b0;
         end else begin
            nib_in   = head_entry.data[7:4];
            ms_in    = MS_NONE;
            last_in  = 1'b0;
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rs_ff   <= rs_in;
      nib_ff  <= nib_in;
      ms_ff   <= ms_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_reg_select = rs_ff;
   assign rsp_nibble     = nib_ff;
   assign rsp_settle_ms  = ms_ff;
   assign rsp_last       = last_ff;

endmodule
`default_nettype wire

/* verif/char_lcd_nibble_interface_core_tb.sv */
// Self-checking testbench that drives LCD requests and checks every nibble word the core writes.
module char_lcd_nibble_interface_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lcdn_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASES = 7;
   localparam int PHASE_WORDS = 48;

   localparam logic [3:0] REQ_UNKNOWN_LOW  = 4'd9;
   localparam logic [3:0] REQ_UNKNOWN_HIGH = 4'd15;
   localparam logic [1:0] SEL_UNUSED       = 2'd3;

   localparam logic [7:0] FUNC_8BIT   = 8'h10;
   localparam logic [7:0] FUNC_2LINE  = 8'h08;
   localparam logic [7:0] ENTRY_INC   = 8'h02;
   localparam logic [7:0] SHIFT_RIGHT = 8'h04;
   localparam logic [7:0] WAKE_CMD    = CMD_FUNC | FUNC_8BIT;

   localparam logic [2:0] CTRL_DISPLAY = 3'b100;
   localparam logic [2:0] CTRL_CURSOR  = 3'b010;
   localparam logic [2:0] CTRL_BLINK   = 3'b001;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] data_byte;
      logic [5:0] column;
      logic [1:0] line;
      logic [1:0] control_select;
      logic       enable;
      logic [2:0] glyph_index;
   } lcd_request_type;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic [5:0] settle_ms;
      logic       last;
   } lcd_write_type;

   class lcd_write_scoreboard;
      logic [5:0] columns = 6'd16;
      logic [2:0] lines = 3'd2;
      logic [5:0] cursor_column = '0;
      logic [1:0] cursor_line = '0;
      logic [2:0] control_bits = '0;
      bit nibble_mode = 1'b0;
      logic [7:0] row_base[4] = '{8'h00, 8'h40, 8'h14, 8'h54};
      lcd_write_type bus_writes_due[$];
      lcd_write_type request_writes[$];
      int unsigned errors = 0;

      function void set_register(logic [0:0] index, logic [5:0] value);
         if (index == CSR_COLUMNS) begin
            columns = value;
         end else begin
            lines = value[2:0];
         end
      endfunction

      function void add_write(logic rs, logic [3:0] nib, logic [5:0] ms);
         request_writes.push_back('{rs, nib, ms, 1'b0});
      endfunction

      function void add_byte(logic rs, logic [7:0] b, logic [5:0] ms);
         if (nibble_mode) begin
            add_write(rs, b[7:4], MS_NONE);
            add_write(rs, b[3:0], ms);
         end else begin
            add_write(rs, b[3:0], ms);
         end
      endfunction

      function logic [7:0] dram_address(logic [5:0] col, logic [1:0] ln);
         return (CMD_DDRAM | row_base[ln]) + {2'b00, col};
      endfunction

      function void update_control(logic [2:0] mask, logic on);
         if (on) begin
            control_bits = control_bits | mask;
         end else begin
            control_bits = control_bits & ~mask;
         end
         add_byte(1'b0, CMD_CTRL | {5'b00000, control_bits}, MS_CMD);
      endfunction

      function void clear_and_home();
         add_byte(1'b0, CMD_CLEAR, MS_CMD);
         add_byte(1'b0, CMD_HOME, MS_HOME);
         cursor_column = '0;
         cursor_line = '0;
      endfunction

      function void note_request(lcd_request_type r);
         logic [5:0] next_column;
         int next_line;
         request_writes.delete();
         case (r.kind)
            REQ_CHAR: begin
               add_byte(1'b1, r.data_byte, MS_NONE);
               next_column = cursor_column + 6'd1;
               if (next_column >= columns) begin
                  next_line = cursor_line + 1;
                  if (next_line >= lines || next_line > 3) next_line = 0;
                  cursor_column = '0;
                  cursor_line = next_line[1:0];
                  add_byte(1'b0, dram_address(cursor_column, cursor_line), MS_CMD);
               end else begin
                  cursor_column = next_column;
               end
            end
            REQ_COMMAND: add_byte(1'b0, r.data_byte, MS_CMD);
            REQ_POS: begin
               if (r.column < columns && r.line < lines) begin
                  add_byte(1'b0, dram_address(r.column, r.line), MS_CMD);
                  cursor_column = r.column;
                  cursor_line = r.line;
               end
            end
            REQ_CONTROL: begin
               case (r.control_select)
                  SEL_DISPLAY: update_control(CTRL_DISPLAY, r.enable);
                  SEL_CURSOR:  update_control(CTRL_CURSOR, r.enable);
                  SEL_BLINK:   update_control(CTRL_BLINK, r.enable);
                  default: ;
               endcase
            end
            REQ_CLEAR: clear_and_home();
            REQ_HOME: begin
               add_byte(1'b0, CMD_HOME, MS_HOME);
               cursor_column = '0;
               cursor_line = '0;
            end
            REQ_GLYPH: add_byte(1'b0, CMD_CGRAM | {2'b00, r.glyph_index, 3'b000}, MS_CMD);
            REQ_ROW: add_byte(1'b1, r.data_byte, MS_NONE);
            REQ_INIT: begin
               repeat (3) add_write(1'b0, WAKE_CMD[7:4], MS_WAKE);
               add_write(1'b0, CMD_FUNC[7:4], MS_WAKE);
               nibble_mode = 1'b1;
               add_byte(1'b0, CMD_FUNC | FUNC_2LINE, MS_FUNC);
               update_control(CTRL_DISPLAY, 1'b1);
               update_control(CTRL_CURSOR, 1'b0);
               update_control(CTRL_BLINK, 1'b0);
               clear_and_home();
               add_byte(1'b0, CMD_ENTRY | ENTRY_INC, MS_CMD);
               add_byte(1'b0, CMD_SHIFT | SHIFT_RIGHT, MS_CMD);
            end
            default: ;
         endcase
         if (request_writes.size() != 0) begin
            request_writes[request_writes.size() - 1].last = 1'b1;
         end
         foreach (request_writes[i]) bus_writes_due.push_back(request_writes[i]);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_write(lcd_write_type got);
         lcd_write_type want;
         if (bus_writes_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none actual rs=%0d nibble=%0d ms=%0d last=%0d",
                     $time, got.reg_select, got.nibble, got.settle_ms, got.last);
            return;
         end
         want = bus_writes_due.pop_front();
         compare_field("reg_select", want.reg_select, got.reg_select);
         compare_field("nibble", want.nibble, got.nibble);
         compare_field("settle_ms", want.settle_ms, got.settle_ms);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic [0:0] csr_index;
   logic [5:0] csr_wdata;
   logic       req_valid;
   logic       req_stall;
   logic [3:0] req_type;
   logic [7:0] req_data_byte;
   logic [5:0] req_column;
   logic [1:0] req_line;
   logic [1:0] req_control_select;
   logic       req_enable;
   logic [2:0] req_glyph_index;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_reg_select;
   logic [3:0] rsp_nibble;
   logic [5:0] rsp_settle_ms;
   logic       rsp_last;

   lcd_write_scoreboard sb = new();
   bit quiet = 1'b0;
   int stall_left = 0;
   int unsigned cycle_count = 0;

   lcd_request_type opening_words[$] = '{
      '{REQ_CHAR,    8'hA5, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_COMMAND, 8'hFF, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_CONTROL, 8'h00, 6'd0,  2'd0, SEL_CURSOR,  1'b1, 3'd0},
      '{REQ_GLYPH,   8'h00, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd7},
      '{REQ_POS,     8'h00, 6'd15, 2'd1, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_UNKNOWN_HIGH, 8'h00, 6'd0, 2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_INIT,    8'h00, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_CHAR,    8'h00, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_CHAR,    8'hFF, 6'd63, 2'd3, SEL_UNUSED,  1'b1, 3'd7},
      '{REQ_COMMAND, 8'h00, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_POS,     8'h00, 6'd15, 2'd1, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_CHAR,    8'h41, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_POS,     8'h00, 6'd16, 2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_POS,     8'h00, 6'd63, 2'd3, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_POS,     8'h00, 6'd0,  2'd2, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_CONTROL, 8'h00, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_CONTROL, 8'h00, 6'd0,  2'd0, SEL_CURSOR,  1'b1, 3'd0},
      '{REQ_CONTROL, 8'h00, 6'd0,  2'd0, SEL_BLINK,   1'b1, 3'd0},
      '{REQ_CONTROL, 8'h00, 6'd0,  2'd0, SEL_BLINK,   1'b0, 3'd0},
      '{REQ_CONTROL, 8'h00, 6'd0,  2'd0, SEL_UNUSED,  1'b1, 3'd0},
      '{REQ_CLEAR,   8'h00, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_HOME,    8'h00, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_GLYPH,   8'h00, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_ROW,     8'hFF, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_ROW,     8'h00, 6'd0,  2'd0, SEL_DISPLAY, 1'b0, 3'd0},
      '{REQ_UNKNOWN_LOW, 8'h00, 6'd0, 2'd0, SEL_DISPLAY, 1'b0, 3'd0}
   };

   char_lcd_nibble_interface_core dut (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_valid, .req_stall, .req_type, .req_data_byte, .req_column, .req_line,
      .req_control_select, .req_enable, .req_glyph_index,
      .rsp_valid, .rsp_stall, .rsp_reg_select, .rsp_nibble, .rsp_settle_ms, .rsp_last
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("char_lcd_nibble_interface_core regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_write('{rsp_reg_select, rsp_nibble, rsp_settle_ms, rsp_last});
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(9, 0) == 0) begin
         stall_left <= $urandom_range(10, 0);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic lcd_request_type random_request();
      lcd_request_type r;
      int pick;
      r.data_byte = 8'($urandom);
      r.column = 6'($urandom);
      r.line = 2'($urandom);
      r.control_select = 2'($urandom);
      r.enable = 1'($urandom);
      r.glyph_index = 3'($urandom);
      pick = $urandom_range(99, 0);
      if (pick < 40) begin
         r.kind = REQ_CHAR;
      end else if (pick < 55) begin
         r.kind = REQ_POS;
         if ($urandom_range(4, 0) != 0) begin
            r.column = 6'($urandom_range(sb.columns - 1, 0));
            r.line = 2'($urandom_range(sb.lines - 1, 0));
         end
      end else if (pick < 65) begin
         r.kind = REQ_CONTROL;
      end else if (pick < 72) begin
         r.kind = REQ_COMMAND;
      end else if (pick < 78) begin
         r.kind = REQ_GLYPH;
      end else if (pick < 84) begin
         r.kind = REQ_ROW;
      end else if (pick < 88) begin
         r.kind = REQ_CLEAR;
      end else if (pick < 92) begin
         r.kind = REQ_HOME;
      end else if (pick < 95) begin
         r.kind = REQ_INIT;
      end else begin
         r.kind = 4'($urandom_range(REQ_UNKNOWN_HIGH, REQ_UNKNOWN_LOW));
      end
      return r;
   endfunction

   task automatic send_request(lcd_request_type r);
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_data_byte <= r.data_byte;
      req_column <= r.column;
      req_line <= r.line;
      req_control_select <= r.control_select;
      req_enable <= r.enable;
      req_glyph_index <= r.glyph_index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      if (!quiet && $urandom_range(4, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(11, 1)) @(posedge clock);
      end
   endtask

   // Wait until every predicted word has arrived, then let the pipeline empty.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.bus_writes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [5:0] cols, logic [2:0] rows);
      csr_we <= 1'b1;
      csr_index <= CSR_COLUMNS;
      csr_wdata <= cols;
      @(posedge clock);
      csr_index <= CSR_LINES;
      csr_wdata <= {3'b000, rows};
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_register(CSR_COLUMNS, cols);
      sb.set_register(CSR_LINES, {3'b000, rows});
   endtask

   initial begin
      int phase_columns[PHASES] = '{40, 1, 40, 1, 23, 16, 16};
      int phase_lines[PHASES] = '{4, 1, 1, 4, 3, 2, 2};
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_COLUMNS;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_type <= REQ_CHAR;
      req_data_byte <= '0;
      req_column <= '0;
      req_line <= '0;
      req_control_select <= SEL_DISPLAY;
      req_enable <= 1'b0;
      req_glyph_index <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_words[i]) send_request(opening_words[i]);
      drain();
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 2) begin
            phase_columns[p] = $urandom_range(40, 1);
            phase_lines[p] = $urandom_range(4, 1);
         end
         quiet = (p == PHASES - 1);
         configure(6'(phase_columns[p]), 3'(phase_lines[p]));
         repeat (PHASE_WORDS) send_request(random_request());
         drain();
      end
      if (sb.errors == 0) begin
         $display("char_lcd_nibble_interface_core regression: pass");
      end else begin
         $display("char_lcd_nibble_interface_core regression: fail");
      end
      $finish;
   end

endmodule
